/* sv/matrix3_inverse_unit_macros.svh */
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/m3i_pkg.sv */
// Types and constants shared by the 3x3 matrix inverse pipeline.
`default_nettype none
package m3i_pkg;
  localparam int EW = 32;
  localparam int CW = 64;
  localparam int DW = 97;
  localparam int MW = 96;
  localparam int RW = 97;
  localparam int QB = 33;
  localparam int NE = 9;
  localparam int ND = 3;
  localparam int PIPE_DEPTH = QB + 6;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [NE];
  typedef logic signed [CW-1:0] cof_t;

  typedef struct packed {
    logic          zero;
    logic [MW-1:0] dmag;
  } det_res_t;

  typedef struct packed {
    logic [CW-1:0] nm;
    logic          neg;
    logic          presat;
  } lane_in_t;
endpackage
`default_nettype wire

/* sv/m3i_in_if.sv */
// Input channel carrying one matrix word.
`default_nettype none
interface m3i_in_if;
  import m3i_pkg::*;
  logic  valid;
  logic  ready;
  elem_t in_c0_r0, in_c0_r1, in_c0_r2;
  elem_t in_c1_r0, in_c1_r1, in_c1_r2;
  elem_t in_c2_r0, in_c2_r1, in_c2_r2;
  modport source(output valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                 in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, input ready);
  modport sink(input valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
               in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, output ready);
endinterface
`default_nettype wire

/* sv/m3i_out_if.sv */
// Result channel carrying one inverse matrix word with its flags.
`default_nettype none
interface m3i_out_if;
  import m3i_pkg::*;
  logic  valid;
  logic  ready;
  elem_t out_c0_r0, out_c0_r1, out_c0_r2;
  elem_t out_c1_r0, out_c1_r1, out_c1_r2;
  elem_t out_c2_r0, out_c2_r1, out_c2_r2;
  logic  singular;
  logic  saturated;
  modport source(output valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                 out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, saturated,
                 input ready);
  modport sink(input valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
               out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, saturated,
               output ready);
endinterface
`default_nettype wire

/* sv/m3i_cofactor.sv */
// Two pipeline stages forming the nine cofactors of the input matrix.
`default_nettype none
module m3i_cofactor (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire m3i_pkg::mat_t a,
  output m3i_pkg::cof_t      cof [m3i_pkg::NE],
  output m3i_pkg::elem_t     row0 [m3i_pkg::ND]
);
  import m3i_pkg::*;

  logic signed [2*EW-1:0] pa_r [NE];
  logic signed [2*EW-1:0] pb_r [NE];
  elem_t                  row0s_r [ND];
  cof_t                   cof_r [NE];
  elem_t                  row0_r [ND];

  for (genvar r = 0; r < ND; r++) begin : g_row
    for (genvar c = 0; c < ND; c++) begin : g_col
      localparam int R1 = (r + 1) % ND;
      localparam int R2 = (r + 2) % ND;
      localparam int C1 = (c + 1) % ND;
      localparam int C2 = (c + 2) % ND;
      always_ff @(posedge clk) begin
        if (en) begin
          pa_r[r*ND+c] <= (2*EW)'(a[C1*ND+R1]) * (2*EW)'(a[C2*ND+R2]);
          pb_r[r*ND+c] <= (2*EW)'(a[C2*ND+R1]) * (2*EW)'(a[C1*ND+R2]);
          cof_r[r*ND+c] <= CW'(pa_r[r*ND+c] - pb_r[r*ND+c]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        row0s_r[r] <= a[r*ND];
        row0_r[r]  <= row0s_r[r];
      end
    end
  end

  assign cof  = cof_r;
  assign row0 = row0_r;
endmodule
`default_nettype wire

/* sv/m3i_det.sv */
// Three pipeline stages forming the determinant and the per-element divide setup.
`default_nettype none
module m3i_det (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire m3i_pkg::elem_t  row0 [m3i_pkg::ND],
  input  wire m3i_pkg::cof_t   cof [m3i_pkg::NE],
  output m3i_pkg::det_res_t    dres,
  output m3i_pkg::lane_in_t    lanes [m3i_pkg::NE]
);
  import m3i_pkg::*;

  logic signed [EW+EW:0]   pl_r [ND];
  logic signed [EW+EW-1:0] ph_r [ND];
  cof_t                    cof3_r [NE];
  logic signed [DW-1:0]    det_r;
  cof_t                    cof4_r [NE];
  det_res_t                dres_r;
  lane_in_t                lanes_r [NE];
  logic signed [DW-1:0]    det_nxt;
  logic [MW-1:0]           dmag_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < ND; c++) begin
        pl_r[c] <= (2*EW+1)'(row0[c]) * (2*EW+1)'($signed({1'b0, cof[c][EW-1:0]}));
        ph_r[c] <= (2*EW)'(row0[c]) * (2*EW)'($signed(cof[c][CW-1:EW]));
      end
      cof3_r <= cof;
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int c = 0; c < ND; c++) begin
      det_nxt = det_nxt + DW'(pl_r[c]) + (DW'(ph_r[c]) <<< EW);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= det_nxt;
      cof4_r <= cof3_r;
    end
  end

  assign dmag_nxt = det_r[DW-1] ? MW'(-det_r) : MW'(det_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dres_r.zero <= (det_r == '0);
      dres_r.dmag <= dmag_nxt;
      for (int k = 0; k < NE; k++) begin
        lanes_r[k].nm     <= cof4_r[k][CW-1] ? CW'(-cof4_r[k]) : CW'(cof4_r[k]);
        lanes_r[k].neg    <= (cof4_r[k] != '0) && (cof4_r[k][CW-1] != det_r[DW-1]);
        lanes_r[k].presat <= {{(RW-CW){1'b0}}, cof4_r[k][CW-1] ? CW'(-cof4_r[k]) :
                             CW'(cof4_r[k])} >= {dmag_nxt, 1'b0};
      end
    end
  end

  assign dres  = dres_r;
  assign lanes = lanes_r;
endmodule
`default_nettype wire

/* sv/m3i_div_lane.sv */
// Pipelined restoring divider with rounding and saturation for one element.
`default_nettype none
module m3i_div_lane (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire m3i_pkg::lane_in_t lin,
  input  wire m3i_pkg::det_res_t dres,
  output m3i_pkg::elem_t         res,
  output logic                   sat,
  output logic                   zero_o
);
  import m3i_pkg::*;

  localparam logic [QB:0] POS_LIM = (QB+1)'({1'b0, {(EW-1){1'b1}}});
  localparam logic [QB:0] NEG_LIM = (QB+1)'({1'b1, {(EW-1){1'b0}}});

  logic [RW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];
  logic [MW-1:0] d_r   [QB];
  logic          neg_r [QB];
  logic          ps_r  [QB];
  logic          z_r   [QB];
  logic [RW-1:0] rin   [QB];
  logic [QB-1:0] qin   [QB];
  logic [MW-1:0] din   [QB];
  logic          negin [QB];
  logic          psin  [QB];
  logic          zin   [QB];
  elem_t         res_r;
  logic          sat_r;
  logic          zero_r;
  logic          rnd;
  logic [QB:0]   qq;
  logic [QB:0]   nq;
  elem_t         res_nxt;
  logic          sat_nxt;

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic          ge;
    logic [RW-1:0] t;
    if (s == 0) begin : g_first
      assign rin[s]   = {{(RW-CW){1'b0}}, lin.nm};
      assign qin[s]   = '0;
      assign din[s]   = dres.dmag;
      assign negin[s] = lin.neg;
      assign psin[s]  = lin.presat;
      assign zin[s]   = dres.zero;
    end else begin : g_rest
      assign rin[s]   = rem_r[s-1];
      assign qin[s]   = q_r[s-1];
      assign din[s]   = d_r[s-1];
      assign negin[s] = neg_r[s-1];
      assign psin[s]  = ps_r[s-1];
      assign zin[s]   = z_r[s-1];
    end
    assign ge = rin[s] >= {1'b0, din[s]};
    assign t  = ge ? rin[s] - {1'b0, din[s]} : rin[s];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= {t[RW-2:0], 1'b0};
        q_r[s]   <= {qin[s][QB-2:0], ge};
        d_r[s]   <= din[s];
        neg_r[s] <= negin[s];
        ps_r[s]  <= psin[s];
        z_r[s]   <= zin[s];
      end
    end
  end

  assign rnd = rem_r[QB-1] >= {1'b0, d_r[QB-1]};
  assign qq  = {1'b0, q_r[QB-1]} + (QB+1)'(rnd);
  assign nq  = ~qq + (QB+1)'(1);

  always_comb begin
    res_nxt = '0;
    sat_nxt = 1'b0;
    if (z_r[QB-1]) begin
      res_nxt = '0;
      sat_nxt = 1'b0;
    end else if (!neg_r[QB-1]) begin
      if (ps_r[QB-1] || qq > POS_LIM) begin
        res_nxt = EW'(POS_LIM);
        sat_nxt = 1'b1;
      end else begin
        res_nxt = qq[EW-1:0];
      end
    end else begin
      if (ps_r[QB-1] || qq > NEG_LIM) begin
        res_nxt = EW'(NEG_LIM);
        sat_nxt = 1'b1;
      end else begin
        res_nxt = nq[EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      sat_r  <= sat_nxt;
      zero_r <= z_r[QB-1];
    end
  end

  assign res    = res_r;
  assign sat    = sat_r;
  assign zero_o = zero_r;
endmodule
`default_nettype wire

/* sv/matrix3_inverse_unit.sv */
// Top level of the pipelined 3x3 fixed-point matrix inverse.
// The input channel takes one word per matrix: nine signed Q16.16 elements in
// column-major order. The result channel returns one word per matrix: the nine
// elements of the inverse in the same order, each rounded to nearest and
// clipped to the Q16.16 range, plus the singular and saturated flags.
// A matrix with a zero determinant gives all-zero elements and singular high.
// The pipeline is 39 register stages deep.
// One word is accepted every cycle while the receiver does not stall; most of
// the depth is the 33 quotient steps of the nine divider lanes, one per stage.
// When the receiver holds ready low with a word waiting, the whole pipeline
// freezes and input ready falls until that word is taken.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
`include "matrix3_inverse_unit_macros.svh"
module matrix3_inverse_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  m3i_in_if.sink    in_ch,
  m3i_out_if.source out_ch
);
  import m3i_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic                  en;
  mat_t                  a;
  cof_t                  cof [NE];
  elem_t                 row0 [ND];
  det_res_t              dres;
  lane_in_t              lanes [NE];
  elem_t                 res [NE];
  logic [NE-1:0]         sat;
  logic [NE-1:0]         zero;

  assign en = !vld_r[PIPE_DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign a[0] = in_ch.in_c0_r0;
  assign a[1] = in_ch.in_c0_r1;
  assign a[2] = in_ch.in_c0_r2;
  assign a[3] = in_ch.in_c1_r0;
  assign a[4] = in_ch.in_c1_r1;
  assign a[5] = in_ch.in_c1_r2;
  assign a[6] = in_ch.in_c2_r0;
  assign a[7] = in_ch.in_c2_r1;
  assign a[8] = in_ch.in_c2_r2;

  assign vld_nxt = en ? {vld_r[PIPE_DEPTH-2:0], in_ch.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  m3i_cofactor u_cof (
    .clk (clk),
    .en  (en),
    .a   (a),
    .cof (cof),
    .row0(row0)
  );

  m3i_det u_det (
    .clk  (clk),
    .en   (en),
    .row0 (row0),
    .cof  (cof),
    .dres (dres),
    .lanes(lanes)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .lin   (lanes[k]),
      .dres  (dres),
      .res   (res[k]),
      .sat   (sat[k]),
      .zero_o(zero[k])
    );
  end

  assign out_ch.valid     = vld_r[PIPE_DEPTH-1];
  assign out_ch.out_c0_r0 = res[0];
  assign out_ch.out_c0_r1 = res[1];
  assign out_ch.out_c0_r2 = res[2];
  assign out_ch.out_c1_r0 = res[3];
  assign out_ch.out_c1_r1 = res[4];
  assign out_ch.out_c1_r2 = res[5];
  assign out_ch.out_c2_r0 = res[6];
  assign out_ch.out_c2_r1 = res[7];
  assign out_ch.out_c2_r2 = res[8];
  assign out_ch.singular  = zero[0];
  assign out_ch.saturated = |sat;

  `M3I_ASSERT_IMP(a_sing_zero, out_ch.valid && out_ch.singular, !out_ch.saturated && out_ch.out_c0_r0 == '0 && out_ch.out_c1_r1 == '0 && out_ch.out_c2_r2 == '0, "singular word has nonzero content")
  `M3I_ASSERT_NXT(a_enter, in_ch.valid && in_ch.ready, vld_r[0], "accepted word did not enter the pipeline")
  `M3I_ASSERT_NXT(a_drain, vld_r[PIPE_DEPTH-2] && en, out_ch.valid, "word lost before the output stage")
endmodule
`default_nettype wire
